// ----- design/mbd_pkg.sv -----
// mbd_pkg: shared types and constants of the mipmap box downsampler
// no dependencies; used by the stream interfaces and the top level

package mbd_pkg;

  localparam int CH_W   = 8;
  localparam int PAIR_W = CH_W + 1;
  localparam int NUM_CH = 4;
  localparam int POS_W  = 11;
  localparam int CFG_W  = 13;
  localparam int CFG_IDX_W = 2;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PAIR_W-1:0] pair_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // one line store entry: four horizontal pair sums
  typedef pair_t [NUM_CH-1:0] pair_vec_t;
  typedef chan_t [NUM_CH-1:0] chan_vec_t;

  // register indexes
  localparam cfg_idx_t CFG_PIXEL_FORMAT  = 2'd0;
  localparam cfg_idx_t CFG_SOURCE_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_SOURCE_HEIGHT = 2'd2;

  // pixel format codes
  localparam logic [1:0] FMT_ONE_CH  = 2'd0;
  localparam logic [1:0] FMT_TWO_CH  = 2'd1;
  localparam logic [1:0] FMT_FOUR_CH = 2'd2;

  localparam logic [1:0] FORMAT_RESET = FMT_FOUR_CH;
  localparam cfg_data_t  DIM_RESET    = 13'd4096;

endpackage

// ----- design/mbd_stream_if.sv -----
// mbd_pix_if and mbd_res_if: valid/ready channels for source pixels and results
// depends on mbd_pkg

interface mbd_pix_if
  import mbd_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t in_ch0;
  chan_t in_ch1;
  chan_t in_ch2;
  chan_t in_ch3;

  modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
  modport sink   (input valid, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

interface mbd_res_if
  import mbd_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t out_ch0;
  chan_t out_ch1;
  chan_t out_ch2;
  chan_t out_ch3;
  pos_t  out_col;
  pos_t  out_row;
  logic  level_done;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                  level_done, input ready);
  modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_col, out_row,
                  level_done, output ready);
endinterface

// ----- design/mipmap_box_downsample.sv -----
// mipmap_box_downsample: 2x2 box filter, one source level in, next mipmap level out
// depends on mbd_pkg, mbd_pix_if and mbd_res_if
//
//   channel   direction  handshake           payload
//   in_s      sink       valid/ready         in_ch0..in_ch3, one source pixel
//   out_m     source     valid/ready         out_ch0..3, out_col, out_row, level_done
//   cfg_*     write-only cfg_we, no wait     cfg_index, cfg_data
//
// one source pixel per clock unless out_m back-pressure stalls the input; the pixel
// closing a 2x2 block goes to the pixel stage (line store read), then average into out reg
// rst_n is synchronous, active low: clears position, left pixel, valids, registers
// the line store has no reset; each entry is written on an even row before it is read
// a stalled result holds in the output register while the pixel stage keeps
// taking pixels; input stalls only when both result stages are full

module mipmap_box_downsample
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_data_t cfg_data,
  mbd_pix_if.sink   in_s,
  mbd_res_if.source out_m
);

  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LA         = $clog2(LINE_DEPTH);

  // configuration registers, kept raw and clamped on use
  logic [1:0] fmt_r;
  cfg_data_t  width_r;
  cfg_data_t  height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FORMAT_RESET;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT:  fmt_r    <= cfg_data[1:0];
        CFG_SOURCE_WIDTH:  width_r  <= cfg_data;
        CFG_SOURCE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes to [2, max]
  logic [CW-1:0] w_c;
  logic [RW-1:0] h_c;

  always_comb begin
    if (width_r < 13'd2) begin
      w_c = CW'(2);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(width_r);
    end
    if (height_r < 13'd2) begin
      h_c = RW'(2);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_c = RW'(MAX_HEIGHT);
    end else begin
      h_c = RW'(height_r);
    end
  end

  // channel enables from the format; code 3 acts as four channels
  logic [NUM_CH-1:0] ch_en;
  always_comb begin
    case (fmt_r)
      FMT_ONE_CH: ch_en = 4'b0001;
      FMT_TWO_CH: ch_en = 4'b0011;
      default:    ch_en = 4'b1111;
    endcase
  end

  // source position of the next pixel
  logic [CW-1:0] col_r, col_nxt, col_inc;
  logic [RW-1:0] row_r, row_nxt, row_inc;
  chan_vec_t     left_r;

  logic [CW-2:0] col_half;
  logic [RW-2:0] row_half;
  logic          in_region, last_col, last_row;

  assign col_half  = col_r[CW-1:1];
  assign row_half  = row_r[RW-1:1];
  assign in_region = (col_r < (w_c & ~CW'(1))) && (row_r < (h_c & ~RW'(1)));
  assign last_col  = (col_half == (w_c[CW-1:1] - (CW-1)'(1)));
  assign last_row  = (row_half == (h_c[RW-1:1] - (RW-1)'(1)));

  // result stages handshake
  logic s1_valid_r, out_valid_r;
  logic adv2, acc;

  assign adv2       = s1_valid_r && (!out_valid_r || out_m.ready);
  assign in_s.ready = !s1_valid_r || adv2;
  assign acc        = in_s.valid && in_s.ready;

  // masked channels and horizontal pair sums
  chan_vec_t ch_m;
  pair_vec_t pair;

  always_comb begin
    ch_m[0] = ch_en[0] ? in_s.in_ch0 : '0;
    ch_m[1] = ch_en[1] ? in_s.in_ch1 : '0;
    ch_m[2] = ch_en[2] ? in_s.in_ch2 : '0;
    ch_m[3] = ch_en[3] ? in_s.in_ch3 : '0;
    for (int i = 0; i < NUM_CH; i++) begin
      pair[i] = {1'b0, left_r[i]} + {1'b0, ch_m[i]};
    end
  end

  logic wr_en, rd_en;
  assign wr_en = acc && in_region && col_r[0] && !row_r[0];
  assign rd_en = acc && in_region && col_r[0] && row_r[0];

  // advance position, wrap at end of row and end of level
  always_comb begin
    col_inc = col_r + CW'(1);
    row_inc = row_r + RW'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (col_inc >= w_c) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_c) ? '0 : row_inc;
      end else begin
        col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (acc && in_region && !col_r[0]) begin
        left_r <= ch_m;
      end
    end
  end

  // line store of even-row pair sums; read data lands with the pixel stage
  pair_vec_t     line_mem [LINE_DEPTH];
  pair_vec_t     top_r;
  logic [LA-1:0] idx;

  assign idx = col_half[LA-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[idx] <= pair;
    end
    if (rd_en) begin
      top_r <= line_mem[idx];
    end
  end

  // pixel stage: bottom pair sums and position of the result
  pair_vec_t         s1_pair_r;
  logic [NUM_CH-1:0] s1_en_r;
  pos_t              s1_col_r, s1_row_r;
  logic              s1_last_r;
  logic [31:0]       col_half32, row_half32;

  assign col_half32 = 32'(col_half);
  assign row_half32 = 32'(row_half);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rd_en) begin
      s1_valid_r <= 1'b1;
    end else if (adv2) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pair_r <= pair;
      s1_en_r   <= ch_en;
      s1_col_r  <= col_half32[POS_W-1:0];
      s1_row_r  <= row_half32[POS_W-1:0];
      s1_last_r <= last_col && last_row;
    end
  end

  // average of the 2x2 block, truncated
  chan_vec_t avg;
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      logic [PAIR_W:0] sum;
      sum    = {1'b0, top_r[i]} + {1'b0, s1_pair_r[i]};
      avg[i] = s1_en_r[i] ? sum[PAIR_W:2] : '0;
    end
  end

  // output register
  chan_vec_t out_ch_r;
  pos_t      out_col_r, out_row_r;
  logic      out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_ch_r   <= avg;
      out_col_r  <= s1_col_r;
      out_row_r  <= s1_row_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_m.valid      = out_valid_r;
  assign out_m.out_ch0    = out_ch_r[0];
  assign out_m.out_ch1    = out_ch_r[1];
  assign out_m.out_ch2    = out_ch_r[2];
  assign out_m.out_ch3    = out_ch_r[3];
  assign out_m.out_col    = out_col_r;
  assign out_m.out_row    = out_row_r;
  assign out_m.level_done = out_last_r;

endmodule
